FILE: src/sfss_pkg.sv
// ---------------------------------------------------------------------------
// sfss_pkg
// Shared types, widths and constants of the starfield star stepper.
// ---------------------------------------------------------------------------
package sfss_pkg;

	// Star table and screen geometry
	localparam int STAR_COUNT_DEF = 80;
	localparam int Z_FAR          = 64;
	localparam int CENTRE_X       = 64;
	localparam int CENTRE_Y       = 32;
	localparam int SCREEN_W       = 128;
	localparam int SCREEN_H       = 64;
	localparam int FAR_LIMIT      = Z_FAR * 2 / 3;
	localparam int MID_LIMIT      = Z_FAR / 3;

	// Field widths
	localparam int X_W        = 7;
	localparam int Y_W        = 6;
	localparam int Z_W        = 7;
	localparam int STAR_W     = X_W + Y_W + Z_W;
	localparam int IDX_W      = 7;
	localparam int STEP_W     = 6;
	localparam int PX_W       = 8;
	localparam int PY_W       = 7;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 6;
	localparam int ADDR_MAX_W = 8;
	localparam int ADDR_EXT_W = IDX_W + ADDR_MAX_W;
	localparam int IDX_CMP_W  = 9;

	// Spawn offsets: flipping the sign bit recenters a raw random field
	localparam logic [X_W-1:0] X_FLIP = X_W'(1 << (X_W - 1));
	localparam logic [Y_W-1:0] Y_FLIP = Y_W'(1 << (Y_W - 1));

	// Configuration reset
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2);

	// xorshift generator
	localparam int              RNG_W    = 16;
	localparam logic [RNG_W-1:0] RNG_SEED = 16'hACE1;
	localparam int              RNG_SH_A = 7;
	localparam int              RNG_SH_B = 9;
	localparam int              RNG_SH_C = 8;

	// Front/back queue
	localparam int QUEUE_DEPTH = 2;

	// Iterative divider
	localparam int DIV_W             = 16;
	localparam int DIVISOR_W         = Z_W;
	localparam int DIV_LANES         = 2;
	localparam int DIV_BITS_PER_STEP = 2;
	localparam int DIV_STEPS         = DIV_W / DIV_BITS_PER_STEP;

	typedef enum logic [0:0] {
		OP_INIT = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	// One queued transaction
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] star_index;
	} item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend_a;
		logic [DIV_W-1:0]     dividend_b;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quot_a;
		logic [DIV_W-1:0]     quot_b;
	} div_rsp_t;

endpackage

FILE: src/sfss_ram.sv
// ---------------------------------------------------------------------------
// sfss_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sfss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/sfss_front.sv
// ---------------------------------------------------------------------------
// sfss_front
// Input side: takes transactions, drops out-of-range indexes and queues the
// rest for the back end in a short FIFO.
// ---------------------------------------------------------------------------
module sfss_front import sfss_pkg::*; #(
	parameter int STAR_COUNT = STAR_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [IDX_W-1:0] star_index,
	output logic             q_valid,
	output item_t            q_item,
	input  logic             q_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             in_range;
	logic             push;
	logic             pop;
	item_t            new_item;

	// Classify the incoming transaction
	assign in_stall = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;
	assign in_range = (IDX_CMP_W'(star_index) < IDX_CMP_W'(STAR_COUNT));
	assign push     = accept && in_range;
	assign pop      = q_pop && q_valid;
	assign new_item = '{op: op_t'(operation), star_index: star_index};

	assign q_valid = (cnt_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

FILE: src/sfss_div.sv
// ---------------------------------------------------------------------------
// sfss_div
// Two-lane restoring divider, two quotient bits per cycle, one lane per
// screen coordinate of the projection.
// ---------------------------------------------------------------------------
module sfss_div import sfss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [DIV_W-1:0]     quo_q [DIV_LANES];
	logic [DIVISOR_W-1:0] rem_q [DIV_LANES];
	logic [DIV_W-1:0]     quo_d [DIV_LANES];
	logic [DIVISOR_W-1:0] rem_d [DIV_LANES];
	logic [DIVISOR_W-1:0] divisor_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// One iteration: DIV_BITS_PER_STEP shift-subtract steps per lane
	always_comb begin
		logic [DIVISOR_W:0]   t;
		logic [DIV_W-1:0]     q;
		logic [DIVISOR_W-1:0] r;
		for (int l = 0; l < DIV_LANES; l++) begin
			r = rem_q[l];
			q = quo_q[l];
			for (int s = 0; s < DIV_BITS_PER_STEP; s++) begin
				t = {r, q[DIV_W-1]};
				q = {q[DIV_W-2:0], 1'b0};
				if (t >= {1'b0, divisor_q}) begin
					t    = t - {1'b0, divisor_q};
					q[0] = 1'b1;
				end
				r = t[DIVISOR_W-1:0];
			end
			quo_d[l] = q;
			rem_d[l] = r;
		end
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q[0]  <= req.dividend_a;
			quo_q[1]  <= req.dividend_b;
			rem_q[0]  <= '0;
			rem_q[1]  <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				quo_q[l] <= quo_d[l];
				rem_q[l] <= rem_d[l];
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot_a = quo_q[0];
	assign rsp.quot_b = quo_q[1];

endmodule

FILE: src/sfss_back.sv
// ---------------------------------------------------------------------------
// sfss_back
// Back end: star table, random generator, projection through the divider
// and the pixel emitter with its output register.
// ---------------------------------------------------------------------------
module sfss_back import sfss_pkg::*; #(
	parameter int STAR_COUNT = STAR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] depth_step,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PX_W-1:0]   pixel_x,
	output logic [PY_W-1:0]   pixel_y,
	output logic              last
);

	localparam int AW    = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
	localparam int SCR_W = DIV_W + 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b000_0001,
		ST_READ = 7'b000_0010,
		ST_RND1 = 7'b000_0100,
		ST_RND2 = 7'b000_1000,
		ST_RND3 = 7'b001_0000,
		ST_DIV  = 7'b010_0000,
		ST_EMIT = 7'b100_0000
	} state_t;

	function automatic logic [RNG_W-1:0] xs_next(input logic [RNG_W-1:0] r);
		logic [RNG_W-1:0] v;
		v = r ^ (r << RNG_SH_A);
		v = v ^ (v >> RNG_SH_B);
		v = v ^ (v << RNG_SH_C);
		return v;
	endfunction

	state_t state_q;
	state_t state_d;

	logic [RNG_W-1:0]  rng_q;
	logic [RNG_W-1:0]  rng_next;
	op_t               op_q;
	logic [AW-1:0]     addr_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [Z_W-1:0]    z_q;
	logic              neg_x_q;
	logic              neg_y_q;
	logic [COL_W-1:0]  sx_q;
	logic [ROW_W-1:0]  sy_q;
	logic [1:0]        k_q;
	logic              out_valid_q;
	logic [PX_W-1:0]   pixel_x_q;
	logic [PY_W-1:0]   pixel_y_q;
	logic              last_q;

	logic [ADDR_EXT_W-1:0] idx_ext;
	logic [AW-1:0]         q_addr;
	logic                  ram_we;
	logic [STAR_W-1:0]     ram_wdata;
	logic [STAR_W-1:0]     ram_rdata;
	logic [X_W-1:0]        rd_x;
	logic [Y_W-1:0]        rd_y;
	logic [Z_W-1:0]        rd_z;
	logic [Z_W-1:0]        z_sub;
	logic                  respawn_rd;
	logic [X_W-1:0]        mag_x;
	logic [Y_W-1:0]        mag_y;
	logic [X_W-1:0]        spawn_x;
	logic [Y_W-1:0]        spawn_y;
	logic [Z_W-1:0]        scatter_z;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [SCR_W-1:0] qx_s;
	logic signed [SCR_W-1:0] qy_s;
	logic signed [SCR_W-1:0] sx_full;
	logic signed [SCR_W-1:0] sy_full;
	logic                    on_screen;
	logic                    far;
	logic                    mid;
	logic                    draw;
	logic [1:0]              k_nxt;
	logic                    out_acc;

	// Star table: {x, y, depth} per entry
	sfss_ram #(
		.WIDTH (STAR_W),
		.DEPTH (STAR_COUNT)
	) u_star_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	sfss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Queue side
	assign idx_ext = ADDR_EXT_W'(q_item.star_index);
	assign q_addr  = idx_ext[AW-1:0];
	assign q_pop   = (state_q == ST_IDLE) && q_valid;

	// Table read decode and depth update
	assign rd_x       = ram_rdata[STAR_W-1 -: X_W];
	assign rd_y       = ram_rdata[Z_W +: Y_W];
	assign rd_z       = ram_rdata[Z_W-1:0];
	assign respawn_rd = (rd_z <= Z_W'(depth_step));
	assign z_sub      = rd_z - Z_W'(depth_step);
	assign mag_x      = rd_x[X_W-1] ? X_W'(-rd_x) : rd_x;
	assign mag_y      = rd_y[Y_W-1] ? Y_W'(-rd_y) : rd_y;

	// Random draws; the init depth is a mask since Z_FAR is a power of two
	assign rng_next  = xs_next(rng_q);
	assign spawn_x   = rng_next[X_W-1:0] ^ X_FLIP;
	assign spawn_y   = rng_next[Y_W-1:0] ^ Y_FLIP;
	assign scatter_z = Z_W'(rng_next & RNG_W'(Z_FAR - 1)) + Z_W'(1);

	// Divider request: projection after a read
	always_comb begin
		div_req.start      = (state_q == ST_READ) && !respawn_rd;
		div_req.dividend_a = DIV_W'(mag_x) * DIV_W'(Z_FAR);
		div_req.dividend_b = DIV_W'(mag_y) * DIV_W'(Z_FAR);
		div_req.divisor    = z_sub;
	end

	// Screen position, truncating toward zero
	assign qx_s    = neg_x_q ? -$signed({1'b0, div_rsp.quot_a}) : $signed({1'b0, div_rsp.quot_a});
	assign qy_s    = neg_y_q ? -$signed({1'b0, div_rsp.quot_b}) : $signed({1'b0, div_rsp.quot_b});
	assign sx_full = qx_s + $signed(SCR_W'(CENTRE_X));
	assign sy_full = qy_s + $signed(SCR_W'(CENTRE_Y));
	assign on_screen = !sx_full[SCR_W-1] && (sx_full < $signed(SCR_W'(SCREEN_W)))
		&& !sy_full[SCR_W-1] && (sy_full < $signed(SCR_W'(SCREEN_H)));

	// Depth band: far stars show only on odd indexes, near stars bloom
	assign far  = (z_q > Z_W'(FAR_LIMIT));
	assign mid  = (z_q > Z_W'(MID_LIMIT));
	assign draw = !far || addr_q[0];

	assign k_nxt   = k_q + 2'd1;
	assign out_acc = out_valid_q && !out_stall;

	// Table writes
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {x_q, y_q, z_q};
		if ((state_q == ST_RND2) && (op_q == OP_STEP)) begin
			ram_we    = 1'b1;
			ram_wdata = {x_q, spawn_y, Z_W'(Z_FAR)};
		end else if (state_q == ST_RND3) begin
			ram_we    = 1'b1;
			ram_wdata = {x_q, y_q, scatter_z};
		end else if ((state_q == ST_DIV) && div_rsp.done && on_screen) begin
			ram_we = 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.op == OP_INIT) ? ST_RND1 : ST_READ;
				end
			end
			ST_READ: state_d = respawn_rd ? ST_RND1 : ST_DIV;
			ST_RND1: state_d = ST_RND2;
			ST_RND2: state_d = (op_q == OP_INIT) ? ST_RND3 : ST_IDLE;
			ST_RND3: state_d = ST_IDLE;
			ST_DIV: begin
				if (div_rsp.done) begin
					if (!on_screen) begin
						state_d = ST_RND1;
					end else if (draw) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (out_acc && last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rng_q       <= RNG_SEED;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_RND1) || (state_q == ST_RND2) || (state_q == ST_RND3)) begin
				rng_q <= rng_next;
			end
			if ((state_q == ST_DIV) && (state_d == ST_EMIT)) begin
				out_valid_q <= 1'b1;
				k_q         <= '0;
			end else if ((state_q == ST_EMIT) && out_acc) begin
				if (last_q) begin
					out_valid_q <= 1'b0;
				end else begin
					k_q <= k_nxt;
				end
			end
		end
	end

	// Star and pixel payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					op_q   <= q_item.op;
					addr_q <= q_addr;
				end
			end
			ST_READ: begin
				x_q     <= rd_x;
				y_q     <= rd_y;
				z_q     <= z_sub;
				neg_x_q <= rd_x[X_W-1];
				neg_y_q <= rd_y[Y_W-1];
			end
			ST_RND1: x_q <= spawn_x;
			ST_RND2: y_q <= spawn_y;
			ST_DIV: begin
				if (div_rsp.done) begin
					sx_q      <= sx_full[COL_W-1:0];
					sy_q      <= sy_full[ROW_W-1:0];
					pixel_x_q <= PX_W'(sx_full[COL_W-1:0]);
					pixel_y_q <= PY_W'(sy_full[ROW_W-1:0]);
					last_q    <= far || mid;
				end
			end
			ST_EMIT: begin
				if (out_acc && !last_q) begin
					pixel_x_q <= PX_W'(sx_q) + PX_W'(k_nxt[0]);
					pixel_y_q <= PY_W'(sy_q) + PY_W'(k_nxt[1]);
					last_q    <= &k_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;

endmodule

FILE: src/starfield_star_stepper_unit.sv
// ---------------------------------------------------------------------------
// starfield_star_stepper_unit
// One star of a 3-D perspective starfield per transaction: init or step.
// ---------------------------------------------------------------------------
// A step transaction reads the star, projects it through the divider and hands
// over its pixels, up to four for a near star; a step that respawns skips the
// division, one whose star leaves the screen respawns after it, and an init
// draws a new position and depth. The divider retires two quotient bits a
// cycle on both coordinates at once.
// Transactions with an index at or above STAR_COUNT are accepted and dropped.
// A two-entry queue sits between the input and the back end, so the input keeps
// taking transactions until the queue is full while pixels wait on the output.
// The star table has no reset; a star must be initialized before it is stepped.
module starfield_star_stepper_unit import sfss_pkg::*; #(
	parameter int STAR_COUNT = STAR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              depth_step_we,
	input  logic [STEP_W-1:0] depth_step,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [IDX_W-1:0]  star_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PX_W-1:0]   pixel_x,
	output logic [PY_W-1:0]   pixel_y,
	output logic              last
);

	logic [STEP_W-1:0] depth_step_q;
	logic              q_valid;
	item_t             q_item;
	logic              q_pop;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_step_q <= STEP_RESET;
		end else if (depth_step_we) begin
			depth_step_q <= depth_step;
		end
	end

	sfss_front #(
		.STAR_COUNT (STAR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.star_index (star_index),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	sfss_back #(
		.STAR_COUNT (STAR_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.depth_step (depth_step_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last       (last)
	);

	// Back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// Only in-range transactions reach the back end
	a_queue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (IDX_CMP_W'(q_item.star_index) < IDX_CMP_W'(STAR_COUNT)))
		else $error("out-of-range index queued");

	// No new transaction starts while pixels are pending
	a_no_pop_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_pop)
		else $error("transaction taken while output pending");

	// Pixels stay within the screen plus one bloom column and row
	a_pixel_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pixel_x <= PX_W'(SCREEN_W)) && (pixel_y <= PY_W'(SCREEN_H))))
		else $error("pixel outside screen bounds");

endmodule

FILE: tb/sv/starfield_star_stepper_checker.sv
// ---------------------------------------------------------------------------
// starfield_star_stepper_checker
// Watches the config port and both channels of the star stepper, keeps its
// own copy of the star table and random generator, predicts the pixels of
// each accepted transaction and compares them in order with what comes out.
// ---------------------------------------------------------------------------
module starfield_star_stepper_checker import sfss_pkg::*; #(
	parameter int STAR_COUNT = STAR_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              depth_step_we,
	input  logic [STEP_W-1:0] depth_step,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              operation,
	input  logic [IDX_W-1:0]  star_index,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PX_W-1:0]   pixel_x,
	input  logic [PY_W-1:0]   pixel_y,
	input  logic              last,
	output int                errors,
	output int                pending,
	output int                pixels_checked
);

	typedef struct packed {
		logic [PX_W-1:0] x;
		logic [PY_W-1:0] y;
		logic            last;
	} pixel_t;

	// Predicted pixels, oldest first
	pixel_t expected_pixels[$];

	// Shadow star table, generator and step register
	logic [X_W-1:0]   star_x [STAR_COUNT];
	logic [Y_W-1:0]   star_y [STAR_COUNT];
	logic [Z_W-1:0]   star_z [STAR_COUNT];
	logic [RNG_W-1:0] shadow_rng;
	logic [STEP_W-1:0] step_size;

	// xorshift advance
	function automatic logic [RNG_W-1:0] draw_random();
		logic [RNG_W-1:0] r;
		r = shadow_rng;
		r = r ^ (r << RNG_SH_A);
		r = r ^ (r >> RNG_SH_B);
		r = r ^ (r << RNG_SH_C);
		shadow_rng = r;
		return r;
	endfunction

	// New position centered on screen, placed at the far plane
	task automatic respawn_star(input int idx);
		logic [RNG_W-1:0] r;
		r = draw_random();
		star_x[idx] = r[X_W-1:0] ^ X_FLIP;
		r = draw_random();
		star_y[idx] = r[Y_W-1:0] ^ Y_FLIP;
		star_z[idx] = Z_W'(Z_FAR);
	endtask

	task automatic push_pixel(input int px, input int py, input logic is_last);
		expected_pixels.push_back('{x: PX_W'(px), y: PY_W'(py), last: is_last});
	endtask

	// Predicts one transaction: updates the shadow table, queues its pixels
	task automatic advance_star(input op_t op, input int idx);
		logic [RNG_W-1:0] r;
		int z, x, y, sx, sy;
		if (idx >= STAR_COUNT)
			return;
		if (op == OP_INIT) begin
			respawn_star(idx);
			r = draw_random();
			star_z[idx] = Z_W'(r % Z_FAR + 1);
			return;
		end
		z = star_z[idx];
		// passed the viewer
		if (z <= int'(step_size)) begin
			respawn_star(idx);
			return;
		end
		z = z - int'(step_size);
		star_z[idx] = Z_W'(z);
		x = $signed(star_x[idx]);
		y = $signed(star_y[idx]);
		sx = x * Z_FAR / z + CENTRE_X;
		sy = y * Z_FAR / z + CENTRE_Y;
		// left the screen
		if (sx < 0 || sx >= SCREEN_W || sy < 0 || sy >= SCREEN_H) begin
			respawn_star(idx);
			return;
		end
		if (z > FAR_LIMIT) begin
			// far stars only twinkle on odd entries
			if (idx % 2 == 1)
				push_pixel(sx, sy, 1'b1);
		end else if (z > MID_LIMIT) begin
			push_pixel(sx, sy, 1'b1);
		end else begin
			push_pixel(sx, sy, 1'b0);
			push_pixel(sx + 1, sy, 1'b0);
			push_pixel(sx, sy + 1, 1'b0);
			push_pixel(sx + 1, sy + 1, 1'b1);
		end
	endtask

	// Compare output transactions, then track config and input transactions
	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			expected_pixels.delete();
			shadow_rng = RNG_SEED;
			step_size = STEP_RESET;
			for (int i = 0; i < STAR_COUNT; i++) begin
				star_x[i] = '0;
				star_y[i] = '0;
				star_z[i] = '0;
			end
			errors         <= 0;
			pending        <= 0;
			pixels_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{x: pixel_x, y: pixel_y, last: last};
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected pixel, expected none, got x=%0d y=%0d last=%0d",
						$time, got.x, got.y, got.last);
					errors <= errors + 1;
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						$display("%0t: pixel mismatch expected x=%0d y=%0d last=%0d,",
							$time, want.x, want.y, want.last);
						$display("%0t:   got x=%0d y=%0d last=%0d",
							$time, got.x, got.y, got.last);
						errors <= errors + 1;
					end
				end
				pixels_checked <= pixels_checked + 1;
			end
			if (depth_step_we)
				step_size = depth_step;
			if (in_valid && !in_stall)
				advance_star(op_t'(operation), int'(star_index));
			pending <= expected_pixels.size();
		end
	end

endmodule

FILE: tb/sv/tb_starfield_star_stepper_unit.sv
// ---------------------------------------------------------------------------
// tb_starfield_star_stepper_unit
// Drives init and step transactions into the star stepper over several
// depth_step settings, with random gaps and output stalls, a long output
// hold-off and idle pauses; the checker beside the block predicts each pixel.
// ---------------------------------------------------------------------------
module tb_starfield_star_stepper_unit;
	import sfss_pkg::*;

	localparam int LIMIT         = 200000;
	localparam int SETTLE_CYCLES = 64;
	localparam int CHOKE_CYCLES  = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              depth_step_we = 1'b0;
	logic [STEP_W-1:0] depth_step = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              operation = OP_INIT;
	logic [IDX_W-1:0]  star_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PX_W-1:0]   pixel_x;
	logic [PY_W-1:0]   pixel_y;
	logic              last;

	int errors, pending, pixels_checked;
	int cycles = 0;
	int n_init = 0, n_step = 0, n_ignored = 0, n_settings = 0;
	int ready_count = 0;
	int choke_count = 0;
	bit choke_phase = 1'b0;
	bit gaps_on = 1'b0;
	bit star_ready [STAR_COUNT_DEF];

	starfield_star_stepper_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.depth_step_we (depth_step_we),
		.depth_step    (depth_step),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.star_index    (star_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.last          (last)
	);

	starfield_star_stepper_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.depth_step_we  (depth_step_we),
		.depth_step     (depth_step),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.star_index     (star_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.last           (last),
		.errors         (errors),
		.pending        (pending),
		.pixels_checked (pixels_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: one long hold-off when asked, random stalls when gaps are on
	always @(posedge clk) begin
		if (choke_phase && choke_count < CHOKE_CYCLES) begin
			out_stall   <= 1'b1;
			choke_count <= choke_count + 1;
		end else if (gaps_on) begin
			out_stall <= ($urandom_range(0, 99) < 31);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// One input transaction, with optional leading gap cycles
	task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx);
		while (gaps_on && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		star_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (idx >= STAR_COUNT_DEF) begin
			n_ignored++;
		end else if (op == OP_INIT) begin
			n_init++;
			if (!star_ready[idx])
				ready_count++;
			star_ready[idx] = 1'b1;
		end else begin
			n_step++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Step register is only touched with the block idle
	task automatic write_step(input logic [STEP_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		depth_step_we <= 1'b1;
		depth_step    <= value;
		@(posedge clk);
		depth_step_we <= 1'b0;
		n_settings++;
	endtask

	// Mostly steps on initialized stars, biased to a small group so they
	// reach the near plane; some inits and some out-of-range noise
	task automatic random_items(input int count);
		int done, roll, idx;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_item(op_t'($urandom_range(0, 1)),
					IDX_W'($urandom_range(STAR_COUNT_DEF, 127)));
			end else begin
				if (roll < ((ready_count < STAR_COUNT_DEF) ? 40 : 18)) begin
					idx = $urandom_range(0, STAR_COUNT_DEF - 1);
					while (ready_count < STAR_COUNT_DEF && star_ready[idx])
						idx = (idx + 1) % STAR_COUNT_DEF;
					send_item(OP_INIT, IDX_W'(idx));
				end else begin
					idx = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 15)
						: $urandom_range(0, STAR_COUNT_DEF - 1);
					while (!star_ready[idx])
						idx = (idx + 1) % STAR_COUNT_DEF;
					send_item(OP_STEP, IDX_W'(idx));
				end
				done++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: out-of-range indexes, first and last stars, far/mid/near,
		// step extremes including zero
		send_item(OP_STEP, IDX_W'(STAR_COUNT_DEF));
		send_item(OP_INIT, IDX_W'(127));
		send_item(OP_INIT, IDX_W'(0));
		send_item(OP_INIT, IDX_W'(1));
		send_item(OP_INIT, IDX_W'(2));
		send_item(OP_INIT, IDX_W'(3));
		send_item(OP_INIT, IDX_W'(STAR_COUNT_DEF - 1));
		send_item(OP_STEP, IDX_W'(0));
		send_item(OP_STEP, IDX_W'(1));
		send_item(OP_STEP, IDX_W'(STAR_COUNT_DEF - 1));
		send_item(OP_STEP, IDX_W'(127));
		write_step(STEP_W'(63));
		send_item(OP_STEP, IDX_W'(0));
		send_item(OP_STEP, IDX_W'(0));
		send_item(OP_STEP, IDX_W'(STAR_COUNT_DEF - 1));
		write_step(STEP_W'(0));
		send_item(OP_STEP, IDX_W'(1));
		send_item(OP_STEP, IDX_W'(2));
		send_item(OP_STEP, IDX_W'(3));
		write_step(STEP_W'(20));
		for (int i = 0; i < 6; i++)
			send_item(OP_STEP, IDX_W'(1 + i % 3));

		// Random phases; the first one runs with no gaps at all
		write_step(STEP_W'(2));
		random_items(24);
		gaps_on = 1'b1;
		write_step(STEP_W'(1));
		random_items(16);
		// long output hold-off while input keeps coming
		choke_phase <= 1'b1;
		random_items(16);
		write_step(STEP_W'(63));
		random_items(12);
		wait_drained();
		random_items(12);
		write_step(STEP_W'(0));
		random_items(24);
		write_step(STEP_W'(7));
		random_items(24);
		write_step(STEP_W'($urandom_range(1, 63)));
		random_items(16);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d init, %0d step and %0d out-of-range transactions",
			n_init, n_step, n_ignored);
		$display("over %0d step settings; checked %0d pixels, %0d errors",
			n_settings + 1, pixels_checked, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
